@@ src/assert_macros.svh @@
// Assertion macros shared by the cipher unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clk edge outside reset
`define CHECK_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Condition that must never be seen at a clk edge outside reset
`define CHECK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

@@ src/kssc_pkg.sv @@
// Shared constants, types and helpers of the keyword shift cipher unit
package kssc_pkg;

  localparam int ALPHABET_MAX = 64;
  localparam int OFF_W        = $clog2(ALPHABET_MAX);
  localparam int LEN_W        = OFF_W + 1;
  localparam int SHIFT_W      = 6;
  localparam int CMP_W        = (LEN_W > SHIFT_W) ? LEN_W : SHIFT_W;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_ENC = 2'd1;
  localparam logic [1:0] CMD_DEC = 2'd2;

  localparam logic [1:0] REG_FIRST = 2'd0;
  localparam logic [1:0] REG_LAST  = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  typedef struct packed {
    logic [7:0]         first_letter;
    logic [7:0]         last_letter;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       data;
    logic             last;
    logic             in_alpha;
    logic [OFF_W-1:0] off;
  } item_t;

  function automatic logic [LEN_W-1:0] alpha_size(input logic [7:0] first,
                                                  input logic [7:0] last);
    logic [8:0] span;
    span = {1'b0, last} - {1'b0, first} + 9'd1;
    if (last < first) begin
      return '0;
    end
    if (span > 9'(ALPHABET_MAX)) begin
      return LEN_W'(ALPHABET_MAX);
    end
    return LEN_W'(span);
  endfunction

endpackage

@@ src/keyword_shift_substitution_cipher_unit.sv @@
// Top level of the keyword shift substitution cipher unit
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_ready  command, byte_in, key_last
//   result    out        res_valid/res_ready  byte_out
//   config    in         wr_en (no wait)      wr_index, wr_data
//
// A text request passes the execution stage as one table RAM read, then the
// result register. A keyword byte is handled in the idle state. The last keyword
// byte starts a rebuild when the alphabet is not empty (shift reduction, keyword
// RAM walk, fill).
// Reset needs no clearing pass: per-entry valid bits return the tables to identity.
// A 2-deep queue decouples intake from execution; intake stalls only when it is full.
module keyword_shift_substitution_cipher_unit import kssc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] command,
  input  logic [7:0] byte_in,
  input  logic       key_last,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] byte_out,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data
);

  logic [7:0]         first_letter;
  logic [7:0]         last_letter;
  logic [SHIFT_W-1:0] shift;
  cfg_t               cfg;
  logic               push;
  item_t              push_item;
  logic               pop;
  item_t              head;
  logic               q_full;
  logic               q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_letter <= 8'd97;
      last_letter  <= 8'd122;
      shift        <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FIRST: first_letter <= wr_data;
        REG_LAST:  last_letter  <= wr_data;
        REG_SHIFT: shift        <= wr_data[SHIFT_W-1:0];
        default: begin
          shift <= shift;
        end
      endcase
    end
  end

  assign cfg.first_letter = first_letter;
  assign cfg.last_letter  = last_letter;
  assign cfg.shift        = shift;

  kssc_front u_front (
    .cfg      (cfg),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .command  (command),
    .byte_in  (byte_in),
    .key_last (key_last),
    .q_full   (q_full),
    .push     (push),
    .push_item(push_item)
  );

  kssc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  kssc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .byte_out (byte_out)
  );

endmodule

@@ src/kssc_ram.sv @@
// Generic single write port RAM with registered read
module kssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/kssc_front.sv @@
// Request intake: alphabet test, letter offset and drop of no-op requests
module kssc_front import kssc_pkg::*; (
  input  cfg_t       cfg,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] command,
  input  logic [7:0] byte_in,
  input  logic       key_last,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  logic [LEN_W-1:0] n;
  logic [7:0]       diff;
  logic             in_alpha;
  logic             keep;

  always_comb begin
    n        = alpha_size(cfg.first_letter, cfg.last_letter);
    diff     = byte_in - cfg.first_letter;
    in_alpha = (byte_in >= cfg.first_letter) && ({1'b0, diff} < {2'b00, n});
    keep     = (command == CMD_ENC) || (command == CMD_DEC) ||
               ((command == CMD_KEY) && (in_alpha || key_last));
    push_item.cmd      = command;
    push_item.data     = byte_in;
    push_item.last     = key_last;
    push_item.in_alpha = in_alpha;
    push_item.off      = in_alpha ? diff[OFF_W-1:0] : '0;
  end

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full && keep;

endmodule

@@ src/kssc_queue.sv @@
// Short request queue between intake and execution
`include "assert_macros.svh"
module kssc_queue import kssc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign head  = slots[rd_ptr];
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `CHECK_HOLDS(a_no_push_full, push |-> !full, "queue pushed while full")
  `CHECK_HOLDS(a_no_pop_empty, pop |-> !empty, "queue popped while empty")

endmodule

@@ src/kssc_back.sv @@
// Execution: keyword collection, table rebuild and text lookup
`include "assert_macros.svh"
module kssc_back import kssc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  item_t      head,
  input  logic       empty,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] byte_out
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_KRD  = 3'd3;
  localparam logic [2:0] S_KWR  = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;

  logic [2:0]              state;
  logic [ALPHABET_MAX-1:0] letter_used;
  logic [ALPHABET_MAX-1:0] fwd_vld;
  logic [ALPHABET_MAX-1:0] inv_vld;
  logic [LEN_W-1:0]        kw_len;
  logic [LEN_W-1:0]        idx;
  logic [SHIFT_W-1:0]      rem;
  logic [OFF_W-1:0]        pos;
  logic [OFF_W-1:0]        fill_i;
  logic                    look_enc;
  logic                    look_inside;
  logic                    look_vld;
  logic [7:0]              look_byte;
  logic [OFF_W-1:0]        look_off;

  logic [LEN_W-1:0] n;
  logic [LEN_W-1:0] pos_p1;
  logic [OFF_W-1:0] pos_adv;
  logic             collect;
  logic             out_free;
  logic             text_pop;
  logic             kw_we;
  logic             kw_fits;
  logic             tbl_we;
  logic [OFF_W-1:0] wsym;
  logic [OFF_W-1:0] kw_rdata;
  logic [OFF_W-1:0] fwd_rdata;
  logic [OFF_W-1:0] inv_rdata;
  logic [OFF_W-1:0] m;

  always_comb begin
    n        = alpha_size(cfg.first_letter, cfg.last_letter);
    pos_p1   = {1'b0, pos} + LEN_W'(1);
    pos_adv  = (pos_p1 == n) ? '0 : pos_p1[OFF_W-1:0];
    collect  = head.in_alpha && !letter_used[head.off] &&
               (kw_len < LEN_W'(ALPHABET_MAX));
    out_free = !res_valid || res_ready;
    kw_fits  = ({1'b0, kw_rdata} < n);
    m        = look_vld ? (look_enc ? fwd_rdata : inv_rdata) : look_off;
    pop      = 1'b0;
    kw_we    = 1'b0;
    tbl_we   = 1'b0;
    wsym     = '0;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          if (head.cmd == CMD_KEY) begin
            pop   = 1'b1;
            kw_we = collect;
          end else if (out_free) begin
            pop = 1'b1;
          end
        end
      end
      S_KWR: begin
        tbl_we = kw_fits;
        wsym   = kw_rdata;
      end
      S_FILL: begin
        tbl_we = !letter_used[fill_i];
        wsym   = fill_i;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    text_pop = pop && (head.cmd != CMD_KEY);
  end

  kssc_ram #(.WIDTH(OFF_W), .DEPTH(ALPHABET_MAX)) u_kw_ram (
    .clk  (clk),
    .we   (kw_we),
    .waddr(kw_len[OFF_W-1:0]),
    .wdata(head.off),
    .re   (state == S_KRD),
    .raddr(idx[OFF_W-1:0]),
    .rdata(kw_rdata)
  );

  kssc_ram #(.WIDTH(OFF_W), .DEPTH(ALPHABET_MAX)) u_fwd_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(pos),
    .wdata(wsym),
    .re   (text_pop),
    .raddr(head.off),
    .rdata(fwd_rdata)
  );

  kssc_ram #(.WIDTH(OFF_W), .DEPTH(ALPHABET_MAX)) u_inv_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(wsym),
    .wdata(pos),
    .re   (text_pop),
    .raddr(head.off),
    .rdata(inv_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      letter_used <= '0;
      fwd_vld     <= '0;
      inv_vld     <= '0;
      kw_len      <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (tbl_we) begin
        fwd_vld[pos]  <= 1'b1;
        inv_vld[wsym] <= 1'b1;
        pos           <= pos_adv;
      end
      case (state)
        S_IDLE: begin
          if (text_pop) begin
            look_enc    <= (head.cmd == CMD_ENC);
            look_inside <= head.in_alpha;
            look_byte   <= head.data;
            look_off    <= head.off;
            look_vld    <= (head.cmd == CMD_ENC) ? fwd_vld[head.off] : inv_vld[head.off];
            state       <= S_LOOK;
          end else if (pop) begin
            if (head.last && (n == '0)) begin
              letter_used <= '0;
              kw_len      <= '0;
            end else if (kw_we) begin
              letter_used[head.off] <= 1'b1;
              kw_len                <= kw_len + LEN_W'(1);
            end
            if (head.last) begin
              fwd_vld <= '0;
              inv_vld <= '0;
              if (n != '0) begin
                rem   <= cfg.shift;
                state <= S_MOD;
              end
            end
          end
        end
        S_LOOK: begin
          res_valid <= 1'b1;
          byte_out  <= look_inside ? cfg.first_letter + 8'(m) : look_byte;
          state     <= S_IDLE;
        end
        S_MOD: begin
          if (CMP_W'(rem) >= CMP_W'(n)) begin
            rem <= rem - SHIFT_W'(n);
          end else begin
            pos    <= OFF_W'(rem);
            idx    <= '0;
            fill_i <= '0;
            state  <= (kw_len == '0) ? S_FILL : S_KRD;
          end
        end
        S_KRD: begin
          state <= S_KWR;
        end
        S_KWR: begin
          idx <= idx + LEN_W'(1);
          if ((idx + LEN_W'(1)) == kw_len) begin
            state <= S_FILL;
          end else begin
            state <= S_KRD;
          end
        end
        S_FILL: begin
          if (({1'b0, fill_i} + LEN_W'(1)) == n) begin
            letter_used <= '0;
            kw_len      <= '0;
            state       <= S_IDLE;
          end else begin
            fill_i <= fill_i + OFF_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CHECK_HOLDS(a_look_out_free, (state == S_LOOK) |-> !res_valid, "lookup with result held")
  `CHECK_HOLDS(a_kw_room, kw_we |-> (kw_len < LEN_W'(ALPHABET_MAX)), "keyword list overrun")

endmodule
